FILE: sv/orot_pkg.sv
package orot_pkg;

  localparam int DIM_BITS     = 12;
  localparam int SERIES_TERMS = 12;
  localparam int Q30          = 30;
  localparam int VW           = 33;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // two setup stages, three stages per series term, two rounding, two corner stages
  localparam int CORNER_LAT = 3 * SERIES_TERMS + 6;

  function automatic int corner_width(int coord_bits);
    return ((coord_bits > DIM_BITS + 1) ? coord_bits : DIM_BITS + 1) + 1;
  endfunction

  function automatic int term_div(int n, bit is_sin);
    return is_sin ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
  endfunction

endpackage

FILE: sv/oriented_rect_overlap_test.sv
// channel   direction  handshake               payload
// command   in         start high, busy low    a_* and b_* center, width, height, angle
// result    out        done_o strobe, 1 cycle  overlap_o
//
// one item per cycle; each accepted item runs through the corner pipeline and the projection stages to done_o
// the latency is set by the sine/cosine series: three stages per term, twelve terms
// busy stays low; every cycle can take a new item
// reset clears only the valid line; items in flight at reset are dropped
// results cannot be held off, each shows for exactly one cycle
module oriented_rect_overlap_test #(
  parameter int COORD_BITS     = 16,
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          a_center_x_i,
  input  logic signed [COORD_BITS-1:0]          a_center_y_i,
  input  logic        [orot_pkg::DIM_BITS-1:0]  a_width_i,
  input  logic        [orot_pkg::DIM_BITS-1:0]  a_height_i,
  input  logic        [ANGLE_BITS-1:0]          a_angle_i,
  input  logic signed [COORD_BITS-1:0]          b_center_x_i,
  input  logic signed [COORD_BITS-1:0]          b_center_y_i,
  input  logic        [orot_pkg::DIM_BITS-1:0]  b_width_i,
  input  logic        [orot_pkg::DIM_BITS-1:0]  b_height_i,
  input  logic        [ANGLE_BITS-1:0]          b_angle_i,
  output logic                                  done_o,
  output logic                                  overlap_o
);
  import orot_pkg::*;

  localparam int CW  = corner_width(COORD_BITS);
  localparam int NW  = CW + 1;
  localparam int PRW = 2 * CW + 1;
  localparam int PJW = 2 * CW + 2;
  localparam int LAT = CORNER_LAT + 5;

  function automatic logic signed [PJW-1:0] smin(input logic signed [PJW-1:0] a,
                                                 input logic signed [PJW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [PJW-1:0] smax(input logic signed [PJW-1:0] a,
                                                 input logic signed [PJW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic signed [CW-1:0]  vxa [4];
  logic signed [CW-1:0]  vya [4];
  logic signed [CW-1:0]  vxb [4];
  logic signed [CW-1:0]  vyb [4];
  logic signed [CW-1:0]  px [8];
  logic signed [CW-1:0]  py [8];
  logic signed [CW-1:0]  px_q [8];
  logic signed [CW-1:0]  py_q [8];
  logic signed [NW-1:0]  nx_d [8];
  logic signed [NW-1:0]  ny_d [8];
  logic signed [NW-1:0]  nx_q [8];
  logic signed [NW-1:0]  ny_q [8];
  logic signed [PRW-1:0] prx_q [8][8];
  logic signed [PRW-1:0] pry_q [8][8];
  logic signed [PJW-1:0] pj_q [8][8];
  logic signed [PJW-1:0] alo_q [8];
  logic signed [PJW-1:0] ahi_q [8];
  logic signed [PJW-1:0] blo_q [8];
  logic signed [PJW-1:0] bhi_q [8];
  logic [7:0]            sep;
  logic                  overlap_q;
  logic [LAT-1:0]        vld_q;

  assign busy = 1'b0;

  orot_corners #(
    .COORD_BITS    (COORD_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_corners_a (
    .clk_i (clk_i),
    .cx_i  (a_center_x_i),
    .cy_i  (a_center_y_i),
    .w_i   (a_width_i),
    .h_i   (a_height_i),
    .ang_i (a_angle_i),
    .vx_o  (vxa),
    .vy_o  (vya)
  );

  orot_corners #(
    .COORD_BITS    (COORD_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_corners_b (
    .clk_i (clk_i),
    .cx_i  (b_center_x_i),
    .cy_i  (b_center_y_i),
    .w_i   (b_width_i),
    .h_i   (b_height_i),
    .ang_i (b_angle_i),
    .vx_o  (vxb),
    .vy_o  (vyb)
  );

  for (genvar k = 0; k < 4; k++) begin : g_pts
    assign px[k]     = vxa[k];
    assign py[k]     = vya[k];
    assign px[k + 4] = vxb[k];
    assign py[k + 4] = vyb[k];
  end

  // edge normals: axes 0..3 from the first rectangle, 4..7 from the second
  for (genvar i = 0; i < 8; i++) begin : g_axis
    localparam int BASE = (i / 4) * 4;
    localparam int E    = i % 4;
    localparam int E2   = (E + 1) % 4;
    assign nx_d[i] = NW'(py[BASE + E2]) - NW'(py[BASE + E]);
    assign ny_d[i] = NW'(px[BASE + E]) - NW'(px[BASE + E2]);
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sep[i] = (ahi_q[i] < blo_q[i]) || (bhi_q[i] < alo_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      nx_q[i] <= nx_d[i];
      ny_q[i] <= ny_d[i];
      px_q[i] <= px[i];
      py_q[i] <= py[i];
      for (int k = 0; k < 8; k++) begin
        prx_q[i][k] <= PRW'(nx_q[i]) * PRW'(px_q[k]);
        pry_q[i][k] <= PRW'(ny_q[i]) * PRW'(py_q[k]);
        pj_q[i][k]  <= PJW'(prx_q[i][k]) + PJW'(pry_q[i][k]);
      end
      alo_q[i] <= smin(smin(pj_q[i][0], pj_q[i][1]), smin(pj_q[i][2], pj_q[i][3]));
      ahi_q[i] <= smax(smax(pj_q[i][0], pj_q[i][1]), smax(pj_q[i][2], pj_q[i][3]));
      blo_q[i] <= smin(smin(pj_q[i][4], pj_q[i][5]), smin(pj_q[i][6], pj_q[i][7]));
      bhi_q[i] <= smax(smax(pj_q[i][4], pj_q[i][5]), smax(pj_q[i][6], pj_q[i][7]));
    end
    overlap_q <= ~|sep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
    end
  end

  assign done_o    = vld_q[LAT-1];
  assign overlap_o = overlap_q;

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted item gave no result");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_self_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (a_center_x_i == b_center_x_i) && (a_center_y_i == b_center_y_i)
     && (a_width_i == b_width_i) && (a_height_i == b_height_i)
     && (a_angle_i == b_angle_i)) |-> ##LAT (done_o && overlap_o))
    else $error("identical rectangles reported apart");

endmodule

FILE: sv/orot_corners.sv
module orot_corners #(
  parameter int COORD_BITS     = 16,
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                               clk_i,
  input  logic signed [COORD_BITS-1:0]                       cx_i,
  input  logic signed [COORD_BITS-1:0]                       cy_i,
  input  logic        [orot_pkg::DIM_BITS-1:0]               w_i,
  input  logic        [orot_pkg::DIM_BITS-1:0]               h_i,
  input  logic        [ANGLE_BITS-1:0]                       ang_i,
  output logic signed [orot_pkg::corner_width(COORD_BITS)-1:0] vx_o [4],
  output logic signed [orot_pkg::corner_width(COORD_BITS)-1:0] vy_o [4]
);
  import orot_pkg::*;

  localparam int CW  = corner_width(COORD_BITS);
  localparam int TW  = TRIG_FRAC_BITS + 3;
  localparam int RSH = Q30 - TRIG_FRAC_BITS;
  localparam int PW  = DIM_BITS + 1 + TW;
  localparam int SW  = ((COORD_BITS > DIM_BITS + 2) ? COORD_BITS : DIM_BITS + 2)
                       + TRIG_FRAC_BITS + 3;
  localparam logic [VW:0] HALF = (VW+1)'((64'd1 << RSH) >> 1);
  localparam int EX [4] = '{-1, 1, 1, -1};
  localparam int EY [4] = '{-1, -1, 1, 1};

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_e;

  typedef struct packed {
    quad_e                        quad;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [DIM_BITS-1:0]          w;
    logic [DIM_BITS-1:0]          h;
  } geo_t;

  typedef struct packed {
    geo_t          g;
    logic [VW-1:0] x2;
    logic [VW-1:0] st;
    logic [VW-1:0] ct;
    logic [VW-1:0] vs;
    logic [VW-1:0] vc;
    logic [VW-1:0] qs;
    logic [VW-1:0] qc;
    logic [VW-1:0] sp;
    logic [VW-1:0] sn;
    logic [VW-1:0] cp;
    logic [VW-1:0] cn;
  } ser_t;

  function automatic logic signed [CW-1:0] trunc_div(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] q;
    q = v >>> (TRIG_FRAC_BITS + 1);
    if (v[SW-1] && (v[TRIG_FRAC_BITS:0] != '0)) begin
      q = q + SW'(1);
    end
    return CW'(q);
  endfunction

  logic [31:0]       t;
  logic [61:0]       xm;
  logic [2*VW-1:0]   x2m;
  ser_t              s1_d, s1_q, c0_d;
  ser_t              pa_q [SERIES_TERMS];
  ser_t              pb_q [SERIES_TERMS];
  ser_t              pc_q [SERIES_TERMS+1];
  logic [VW-1:0]     sv_d, cv_d, sv_q, cv_q;
  geo_t              gf_q, gt_q;
  logic signed [TW-1:0] rsv, rcv, cos_d, sin_d, cos_q, sin_q;
  logic signed [PW-1:0] wc_q, hs_q, ws_q, hc_q;
  logic signed [COORD_BITS-1:0] cxg_q, cyg_q;
  logic signed [SW-1:0] nx_d [4];
  logic signed [SW-1:0] ny_d [4];
  logic signed [CW-1:0] vx_q [4];
  logic signed [CW-1:0] vy_q [4];

  // angle reduction to quadrant and radians in Q30
  assign t  = 32'(ang_i) << (32 - ANGLE_BITS);
  assign xm = 62'(t[29:0]) * 62'(PI_Q30);

  always_comb begin
    s1_d         = '0;
    s1_d.st      = VW'(xm[61:31]);
    s1_d.g.quad  = quad_e'(t[31:30]);
    s1_d.g.cx    = cx_i;
    s1_d.g.cy    = cy_i;
    s1_d.g.w     = w_i;
    s1_d.g.h     = h_i;
  end

  assign x2m = (2*VW)'(s1_q.st) * (2*VW)'(s1_q.st);

  always_comb begin
    c0_d    = s1_q;
    c0_d.x2 = x2m[VW+29:30];
    c0_d.ct = VW'(1) << Q30;
    c0_d.sp = s1_q.st;
    c0_d.cp = VW'(1) << Q30;
    c0_d.sn = '0;
    c0_d.cn = '0;
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    pc_q[0] <= c0_d;
  end

  for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_term
    localparam int DS = term_div(n, 1'b1);
    localparam int DC = term_div(n, 1'b0);
    localparam logic [VW-1:0] RS = VW'((64'd1 << VW) / DS);
    localparam logic [VW-1:0] RC = VW'((64'd1 << VW) / DC);

    logic [2*VW-1:0] ms, mc, ns, nc;
    logic [VW-1:0]   rs, rc;
    ser_t            a_d, b_d, c_d;

    // term product, then reciprocal quotient, then remainder fix and accumulate
    always_comb begin
      a_d    = pc_q[n-1];
      ms     = (2*VW)'(pc_q[n-1].st) * (2*VW)'(pc_q[n-1].x2);
      mc     = (2*VW)'(pc_q[n-1].ct) * (2*VW)'(pc_q[n-1].x2);
      a_d.vs = ms[VW+29:30];
      a_d.vc = mc[VW+29:30];
    end

    always_comb begin
      b_d    = pa_q[n-1];
      ns     = (2*VW)'(pa_q[n-1].vs) * (2*VW)'(RS);
      nc     = (2*VW)'(pa_q[n-1].vc) * (2*VW)'(RC);
      b_d.qs = ns[2*VW-1:VW];
      b_d.qc = nc[2*VW-1:VW];
    end

    always_comb begin
      c_d    = pb_q[n-1];
      rs     = pb_q[n-1].vs - VW'(pb_q[n-1].qs * VW'(DS));
      rc     = pb_q[n-1].vc - VW'(pb_q[n-1].qc * VW'(DC));
      c_d.st = pb_q[n-1].qs + VW'(rs >= VW'(DS));
      c_d.ct = pb_q[n-1].qc + VW'(rc >= VW'(DC));
      if ((n % 2) == 1) begin
        c_d.sn = pb_q[n-1].sn + c_d.st;
        c_d.cn = pb_q[n-1].cn + c_d.ct;
      end else begin
        c_d.sp = pb_q[n-1].sp + c_d.st;
        c_d.cp = pb_q[n-1].cp + c_d.ct;
      end
    end

    always_ff @(posedge clk_i) begin
      pa_q[n-1] <= a_d;
      pb_q[n-1] <= b_d;
      pc_q[n]   <= c_d;
    end
  end

  assign sv_d = (pc_q[SERIES_TERMS].sp > pc_q[SERIES_TERMS].sn) ?
                pc_q[SERIES_TERMS].sp - pc_q[SERIES_TERMS].sn : '0;
  assign cv_d = (pc_q[SERIES_TERMS].cp > pc_q[SERIES_TERMS].cn) ?
                pc_q[SERIES_TERMS].cp - pc_q[SERIES_TERMS].cn : '0;

  // round half up on magnitude, then quadrant mapping
  assign rsv = TW'(((VW+1)'(sv_q) + HALF) >> RSH);
  assign rcv = TW'(((VW+1)'(cv_q) + HALF) >> RSH);

  always_comb begin
    case (gf_q.quad)
      QUAD_I: begin
        cos_d = rcv;
        sin_d = rsv;
      end
      QUAD_II: begin
        cos_d = -rsv;
        sin_d = rcv;
      end
      QUAD_III: begin
        cos_d = -rcv;
        sin_d = -rsv;
      end
      QUAD_IV: begin
        cos_d = rsv;
        sin_d = -rcv;
      end
      default: begin
        cos_d = rcv;
        sin_d = rsv;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nx_d[k] = (SW'(cxg_q) <<< (TRIG_FRAC_BITS + 1))
              + ((EX[k] > 0) ? SW'(wc_q) : -SW'(wc_q))
              - ((EY[k] > 0) ? SW'(hs_q) : -SW'(hs_q));
      ny_d[k] = (SW'(cyg_q) <<< (TRIG_FRAC_BITS + 1))
              + ((EX[k] > 0) ? SW'(ws_q) : -SW'(ws_q))
              + ((EY[k] > 0) ? SW'(hc_q) : -SW'(hc_q));
    end
  end

  always_ff @(posedge clk_i) begin
    sv_q  <= sv_d;
    cv_q  <= cv_d;
    gf_q  <= pc_q[SERIES_TERMS].g;
    cos_q <= cos_d;
    sin_q <= sin_d;
    gt_q  <= gf_q;
    wc_q  <= PW'(signed'({1'b0, gt_q.w})) * PW'(cos_q);
    hs_q  <= PW'(signed'({1'b0, gt_q.h})) * PW'(sin_q);
    ws_q  <= PW'(signed'({1'b0, gt_q.w})) * PW'(sin_q);
    hc_q  <= PW'(signed'({1'b0, gt_q.h})) * PW'(cos_q);
    cxg_q <= gt_q.cx;
    cyg_q <= gt_q.cy;
    for (int k = 0; k < 4; k++) begin
      vx_q[k] <= trunc_div(nx_d[k]);
      vy_q[k] <= trunc_div(ny_d[k]);
    end
  end

  assign vx_o = vx_q;
  assign vy_o = vy_q;

endmodule

FILE: dv/tb_oriented_rect_overlap_test.sv
module tb_oriented_rect_overlap_test;
  import orot_pkg::*;

  localparam int LATENCY   = CORNER_LAT + 5;
  localparam int IDLE_LIMIT = 20 * LATENCY + 2000;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [15:0]        ang;
  } rect_t;

  typedef struct packed {
    rect_t a;
    rect_t b;
  } pair_t;

  logic clk_i, rst_ni;
  logic start, busy, done_o, overlap_o;
  rect_t ra, rb;

  oriented_rect_overlap_test u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .a_center_x_i(ra.cx), .a_center_y_i(ra.cy), .a_width_i(ra.w),
    .a_height_i(ra.h), .a_angle_i(ra.ang),
    .b_center_x_i(rb.cx), .b_center_y_i(rb.cy), .b_width_i(rb.w),
    .b_height_i(rb.h), .b_angle_i(rb.ang),
    .done_o(done_o), .overlap_o(overlap_o)
  );

  pair_t pending_q[$];
  logic  expected_overlap_q[$];
  int    errors, sent, received, hits, idle_cycles;
  int    gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // trig in Q1.16 from a binary angle
  task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] t;
    logic [1:0]  quad;
    longint unsigned r, x, x2, st, ct, sp, sn, cp, cn, sv, cv, half;
    longint cm, sm;
    t = {ang, 16'd0};
    quad = t[31:30];
    r = t[29:0];
    x = (r * PI_Q30) >> 31;
    x2 = (x * x) >> 30;
    st = x; ct = 64'd1 << 30;
    sp = st; sn = 0; cp = ct; cn = 0;
    for (int n = 1; n <= 12; n++) begin
      st = ((st * x2) >> 30) / ((2 * n) * (2 * n + 1));
      ct = ((ct * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sn += st; cn += ct;
      end else begin
        sp += st; cp += ct;
      end
    end
    sv = sp > sn ? sp - sn : 0;
    cv = cp > cn ? cp - cn : 0;
    half = 64'd1 << 13;
    sm = longint'((sv + half) >> 14);
    cm = longint'((cv + half) >> 14);
    case (quad)
      2'd0: begin c = cm;  s = sm;  end
      2'd1: begin c = -sm; s = cm;  end
      2'd2: begin c = -cm; s = -sm; end
      default: begin c = sm; s = -cm; end
    endcase
  endtask

  task automatic rect_corners(input rect_t rc, output longint vx[4], output longint vy[4]);
    longint c, s, ew, eh, cx, cy, w, h;
    int ex[4], ey[4];
    ex = '{-1, 1, 1, -1};
    ey = '{-1, -1, 1, 1};
    cx = rc.cx; cy = rc.cy; w = rc.w; h = rc.h;
    sin_cos(rc.ang, c, s);
    for (int k = 0; k < 4; k++) begin
      ew = ex[k] * w;
      eh = ey[k] * h;
      vx[k] = (cx * 131072 + ew * c - eh * s) / 131072;
      vy[k] = (cy * 131072 + ew * s + eh * c) / 131072;
    end
  endtask

  task automatic span(input longint vx[4], input longint vy[4], input longint nx,
                      input longint ny, output longint lo, output longint hi);
    longint p;
    lo = nx * vx[0] + ny * vy[0];
    hi = lo;
    for (int k = 1; k < 4; k++) begin
      p = nx * vx[k] + ny * vy[k];
      if (p < lo) lo = p;
      if (p > hi) hi = p;
    end
  endtask

  task automatic predict_overlap(input pair_t p, output logic hit);
    longint ax[4], ay[4], bx[4], by[4], px[4], py[4];
    longint nx, ny, alo, ahi, blo, bhi;
    int e2;
    rect_corners(p.a, ax, ay);
    rect_corners(p.b, bx, by);
    hit = 1'b1;
    for (int which = 0; which < 2; which++) begin
      for (int k = 0; k < 4; k++) begin
        if (which == 0) begin
          px[k] = ax[k];
          py[k] = ay[k];
        end else begin
          px[k] = bx[k];
          py[k] = by[k];
        end
      end
      for (int e = 0; e < 4; e++) begin
        e2 = (e + 1) % 4;
        nx = py[e2] - py[e];
        ny = px[e] - px[e2];
        span(ax, ay, nx, ny, alo, ahi);
        span(bx, by, nx, ny, blo, bhi);
        if (ahi < blo || bhi < alo) hit = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic rect_t rand_rect(input int spread, input int maxdim);
    rect_t r;
    int sz;
    r.cx = 16'($signed($urandom_range(0, 2 * spread)) - spread);
    r.cy = 16'($signed($urandom_range(0, 2 * spread)) - spread);
    sz = $urandom_range(0, 3) == 0 ? 4095 : maxdim;
    r.w = 12'($urandom_range(0, sz));
    r.h = 12'($urandom_range(0, sz));
    r.ang = 16'($urandom);
    return r;
  endfunction

  function automatic rect_t mk(int cx, int cy, int w, int h, int ang);
    rect_t r;
    r.cx = 16'(cx); r.cy = 16'(cy); r.w = 12'(w); r.h = 12'(h); r.ang = 16'(ang);
    return r;
  endfunction

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      ra <= '0;
      rb <= '0;
    end else begin
      if (start && !busy) begin
        sent++;
      end
      if ((!start || !busy) && pending_q.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        pair_t p;
        p = pending_q.pop_front();
        ra <= p.a;
        rb <= p.b;
        start <= 1'b1;
      end else if (!start || !busy) begin
        start <= 1'b0;
        ra <= rect_t'({$urandom, $urandom, $urandom});
        rb <= rect_t'({$urandom, $urandom, $urandom});
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        logic hit;
        predict_overlap({ra, rb}, hit);
        expected_overlap_q.push_back(hit);
      end
      if (done_o) begin
        received++;
        if (expected_overlap_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          logic want;
          want = expected_overlap_q.pop_front();
          hits += int'(want);
          if (overlap_o !== want)
            report_mismatch($sformatf("overlap got %b want %b", overlap_o, want));
        end
      end
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("tb_oriented_rect_overlap_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    pair_t p;
    int phase_gap[4];
    phase_gap = '{0, 68, 0, 8};
    errors = 0; sent = 0; received = 0; hits = 0; idle_cycles = 0;
    gap_pct = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, touching, zero size, every quadrant
    pending_q.push_back({mk(0, 0, 10, 10, 0), mk(10, 0, 10, 10, 0)});
    pending_q.push_back({mk(0, 0, 10, 10, 0), mk(11, 0, 10, 10, 0)});
    pending_q.push_back({mk(0, 0, 10, 10, 0), mk(12, 0, 10, 10, 0)});
    pending_q.push_back({mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0)});
    pending_q.push_back({mk(0, 0, 0, 20, 16384), mk(5, 0, 20, 0, 0)});
    pending_q.push_back({mk(0, 0, 20, 0, 100), mk(100, 100, 0, 0, 0)});
    pending_q.push_back({mk(-32768, -32768, 4095, 4095, 65535),
                         mk(32767, 32767, 4095, 4095, 0)});
    pending_q.push_back({mk(32767, -32768, 4095, 4095, 8192),
                         mk(32767, -32768, 4095, 4095, 57344)});
    pending_q.push_back({mk(-32768, 32767, 4095, 0, 32768),
                         mk(-32768, 32767, 0, 4095, 49152)});
    for (int q = 0; q < 4; q++) begin
      pending_q.push_back({mk(0, 0, 40, 10, q * 16384 + 4096), mk(20, 20, 10, 40, q * 16384)});
      pending_q.push_back({mk(0, 0, 100, 4, q * 16384 + 8192), mk(30, 30, 4, 100, 65535)});
    end
    pending_q.push_back({mk(0, 0, 2048, 1, 21845), mk(0, 0, 1, 2048, 43690)});
    pending_q.push_back({mk(-1, -1, 1, 1, 1), mk(1, 1, 1, 1, 32767)});
    pending_q.push_back({mk(0, 0, 4095, 4095, 0), mk(4095, 0, 4095, 4095, 0)});
    pending_q.push_back({mk(0, 0, 4095, 4095, 0), mk(4096, 0, 4095, 4095, 0)});

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = phase_gap[ph];
      for (int i = 0; i < 120; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            p.a = rect_t'({$urandom, $urandom, $urandom});
            p.b = rect_t'({$urandom, $urandom, $urandom});
          end
          1, 2: begin
            p.a = rand_rect(30000, 4095);
            p.b = rand_rect(30000, 4095);
          end
          default: begin
            p.a = rand_rect(200, 150);
            p.b = rand_rect(200, 150);
            p.b.cx = p.a.cx + 16'($signed($urandom_range(0, 300)) - 150);
            p.b.cy = p.a.cy + 16'($signed($urandom_range(0, 300)) - 150);
          end
        endcase
        pending_q.push_back(p);
      end
      while (pending_q.size() > 0 || start) @(posedge clk_i);
    end
    while (expected_overlap_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("ran %0d rectangle pairs, %0d results, %0d overlapping", sent, received, hits);
    $display("idle phases covered: none, sender gaps, and light gaps");
    if (errors == 0) begin
      $display("tb_oriented_rect_overlap_test OK");
    end else begin
      $display("tb_oriented_rect_overlap_test NOT OK");
    end
    $finish;
  end

endmodule
